// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;
  localparam int CELLS     = ROWS * COLUMNS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int GCNT_W = $clog2(TAB_WIDTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_READ      = 2'd1,
    OP_CLR_SCR   = 2'd2,
    OP_CLR_ROW   = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  character;
    logic [10:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
  } out_item_t;

endpackage

// ===== sv/text_console_writer_unit.sv =====
// Text console writer: screen store, cursor and the sequencer that walks them.
//
// Usage: an item on the in_ channel is one operation: put a character, read a
// cell, clear the screen or clear the current row. Every item gives exactly
// one result item on the out_ channel, carrying the read cell (zero for other
// operations) and the cursor position after the operation.
// The cfg_ channel writes the attribute byte used for every cell written; it
// is always ready and should only be written while the block is idle.
// The block takes one item at a time: in_ready is high only while idle, and
// falls from acceptance until the result item has been taken.
// A tab writes TAB_WIDTH cells at one a cycle, unless a line wrap comes
// between. Clearing a row or the screen sweeps its cells through the single
// memory write port. A scroll copies the store up one row, one cell a cycle
// through the registered read port, then clears the last row.
// Reset clears the cursor and sets the attribute to 15; the screen store is
// not cleared and holds nothing defined until cells are written or cleared.
// When the receiver stalls, the result item holds on out_data until taken.
module text_console_writer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GLYPH,
    S_NEWLINE,
    S_COPY,
    S_SWEEP,
    S_RDWAIT,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [7:0]          attr_r, attr_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ADDR_W-1:0]   row_base_r, row_base_nxt;
  logic [GCNT_W-1:0]   gcnt_r, gcnt_nxt;
  logic [7:0]          gch_r, gch_nxt;
  logic [ADDR_W-1:0]   copy_ptr_r, copy_ptr_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [ADDR_W-1:0]   sweep_ptr_r, sweep_ptr_nxt;
  logic [ADDR_W-1:0]   sweep_end_r, sweep_end_nxt;
  logic [7:0]          res_char_r, res_char_nxt;
  logic [7:0]          res_color_r, res_color_nxt;

  logic [15:0]         mem [CELLS];
  logic [15:0]         rdata_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  logic [15:0]         mem_wd;
  logic [ADDR_W-1:0]   rd_addr;
  logic                in_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  assign out_data.cell_char  = res_char_r;
  assign out_data.cell_color = res_color_r;
  assign out_data.cursor_col = col_r;
  assign out_data.cursor_row = row_r;

  always_comb begin
    state_nxt     = state_r;
    attr_nxt      = attr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    row_base_nxt  = row_base_r;
    gcnt_nxt      = gcnt_r;
    gch_nxt       = gch_r;
    copy_ptr_nxt  = copy_ptr_r;
    pend_addr_nxt = pend_addr_r;
    pend_v_nxt    = pend_v_r;
    sweep_ptr_nxt = sweep_ptr_r;
    sweep_end_nxt = sweep_end_r;
    res_char_nxt  = res_char_r;
    res_color_nxt = res_color_r;
    mem_we        = 1'b0;
    mem_wa        = sweep_ptr_r;
    mem_wd        = {attr_r, CH_SPACE};
    rd_addr       = copy_ptr_r + ADDR_W'(COLUMNS);

    if (cfg_valid && cfg_ready) begin
      attr_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        rd_addr = in_data.cell_address;
        if (in_acc) begin
          res_char_nxt  = 8'd0;
          res_color_nxt = 8'd0;
          gcnt_nxt      = '0;
          unique case (in_data.operation)
            OP_PUT: begin
              unique case (in_data.character)
                CH_CR, CH_LF: begin
                  state_nxt = S_NEWLINE;
                end
                CH_TAB: begin
                  gch_nxt   = CH_SPACE;
                  gcnt_nxt  = GCNT_W'(TAB_WIDTH);
                  state_nxt = S_GLYPH;
                end
                CH_BS: begin
                  if (col_r != '0) begin
                    col_nxt = col_r - 1'b1;
                  end else if (row_r != '0) begin
                    row_nxt      = row_r - 1'b1;
                    row_base_nxt = row_base_r - ADDR_W'(COLUMNS);
                  end
                  state_nxt = S_OUT;
                end
                default: begin
                  gch_nxt   = in_data.character;
                  gcnt_nxt  = GCNT_W'(1);
                  state_nxt = S_GLYPH;
                end
              endcase
            end
            OP_READ: begin
              if (in_data.cell_address < ADDR_W'(CELLS)) begin
                state_nxt = S_RDWAIT;
              end else begin
                state_nxt = S_OUT;
              end
            end
            OP_CLR_SCR: begin
              sweep_ptr_nxt = '0;
              sweep_end_nxt = ADDR_W'(CELLS - 1);
              state_nxt     = S_SWEEP;
            end
            OP_CLR_ROW: begin
              sweep_ptr_nxt = row_base_r;
              sweep_end_nxt = row_base_r + ADDR_W'(COLUMNS - 1);
              state_nxt     = S_SWEEP;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_GLYPH: begin
        if (gcnt_r == '0) begin
          state_nxt = S_OUT;
        end else if (col_r >= COL_W'(COLUMNS)) begin
          // The line is full: take a new line first, then come back here.
          state_nxt = S_NEWLINE;
        end else begin
          mem_we   = 1'b1;
          mem_wa   = row_base_r + ADDR_W'(col_r);
          mem_wd   = {attr_r, gch_r};
          col_nxt  = col_r + 1'b1;
          gcnt_nxt = gcnt_r - 1'b1;
        end
      end

      S_NEWLINE: begin
        col_nxt = '0;
        if (row_r < ROW_W'(ROWS - 1)) begin
          row_nxt      = row_r + 1'b1;
          row_base_nxt = row_base_r + ADDR_W'(COLUMNS);
          state_nxt    = S_GLYPH;
        end else begin
          copy_ptr_nxt = '0;
          pend_v_nxt   = 1'b0;
          state_nxt    = S_COPY;
        end
      end

      S_COPY: begin
        // Reads run one row ahead of writes, so a cell is always read before
        // it is overwritten. Each write lands in the cycle after its read.
        if (pend_v_r) begin
          mem_we = 1'b1;
          mem_wa = pend_addr_r;
          mem_wd = rdata_r;
        end
        if (copy_ptr_r < ADDR_W'(CELLS - COLUMNS)) begin
          pend_v_nxt    = 1'b1;
          pend_addr_nxt = copy_ptr_r;
          copy_ptr_nxt  = copy_ptr_r + 1'b1;
        end else begin
          pend_v_nxt    = 1'b0;
          sweep_ptr_nxt = ADDR_W'(CELLS - COLUMNS);
          sweep_end_nxt = ADDR_W'(CELLS - 1);
          state_nxt     = S_SWEEP;
        end
      end

      S_SWEEP: begin
        mem_we        = 1'b1;
        sweep_ptr_nxt = sweep_ptr_r + 1'b1;
        if (sweep_ptr_r == sweep_end_r) begin
          state_nxt = S_GLYPH;
        end
      end

      S_RDWAIT: begin
        res_char_nxt  = rdata_r[7:0];
        res_color_nxt = rdata_r[15:8];
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      attr_r     <= 8'd15;
      col_r      <= '0;
      row_r      <= '0;
      row_base_r <= '0;
      gcnt_r     <= '0;
      pend_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      attr_r     <= attr_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
      gcnt_r     <= gcnt_nxt;
      pend_v_r   <= pend_v_nxt;
    end
    gch_r       <= gch_nxt;
    copy_ptr_r  <= copy_ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
    sweep_ptr_r <= sweep_ptr_nxt;
    sweep_end_r <= sweep_end_nxt;
    res_char_r  <= res_char_nxt;
    res_color_r <= res_color_nxt;
  end

  // Screen store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

endmodule

// ===== sv/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tcw_pkg::out_item_t out_data
);
  import tcw_pkg::*;

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // One item at a time: never ready for input while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result item is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted item");

  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("block not idle after its result item was taken");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cursor_row < 5'(ROWS)) &&
                  (out_data.cursor_col <= 7'(COLUMNS)))
    else $error("cursor outside the screen");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);

// ===== verif/tb_text_console_writer_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the text console writer against a screen predictor.
module tb_text_console_writer_unit;
  import tcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HEAVY_MAX      = 300;
  localparam int REPORT_MAX     = 10;
  localparam int ADDR_TOP       = 2047;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  always #4 clk = ~clk;

  text_console_writer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Screen and cursor as the block should hold them.
  logic [15:0] screen_model [CELLS];
  bit          cell_defined [CELLS];
  bit          any_defined = 1'b0;
  logic [10:0] last_written = '0;
  int          cur_col = 0;
  int          cur_row = 0;
  logic [7:0]  attr_reg = 8'd15;

  out_item_t   awaited_results [$];

  int errors = 0, mismatches = 0, items_sent = 0, results_seen = 0;
  int scrolls = 0, wraps = 0, reads_done = 0, heavy_ops = 0, attr_writes = 0;
  int stall_left = 0, quiet_cycles = 0;
  bit steady = 1'b0, calm = 1'b0;

  function automatic void wipe_line(int r);
    for (int c = 0; c < COLUMNS; c++) begin
      screen_model[r * COLUMNS + c] = {attr_reg, CH_SPACE};
      cell_defined[r * COLUMNS + c] = 1'b1;
    end
    any_defined  = 1'b1;
    last_written = 11'(r * COLUMNS);
  endfunction

  function automatic void advance_line();
    cur_col = 0;
    if (cur_row < ROWS - 1) begin
      cur_row++;
    end else begin
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        screen_model[i] = screen_model[i + COLUMNS];
        cell_defined[i] = cell_defined[i + COLUMNS];
      end
      wipe_line(ROWS - 1);
      scrolls++;
      heavy_ops++;
    end
  endfunction

  function automatic void place_glyph(logic [7:0] ch);
    int idx;
    if (cur_col >= COLUMNS) begin
      advance_line();
      wraps++;
    end
    idx = cur_row * COLUMNS + cur_col;
    screen_model[idx] = {attr_reg, ch};
    cell_defined[idx] = 1'b1;
    any_defined  = 1'b1;
    last_written = 11'(idx);
    cur_col++;
  endfunction

  function automatic out_item_t console_apply(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.operation)
      OP_PUT: begin
        case (it.character)
          CH_CR, CH_LF: advance_line();
          CH_TAB: repeat (TAB_WIDTH) place_glyph(CH_SPACE);
          CH_BS: begin
            if (cur_col > 0) cur_col--;
            else if (cur_row > 0) cur_row--;
          end
          default: place_glyph(it.character);
        endcase
      end
      OP_READ: begin
        reads_done++;
        if (it.cell_address < CELLS) begin
          r.cell_char  = screen_model[it.cell_address][7:0];
          r.cell_color = screen_model[it.cell_address][15:8];
        end
      end
      OP_CLR_SCR: begin
        heavy_ops++;
        for (int row_i = 0; row_i < ROWS; row_i++) wipe_line(row_i);
      end
      OP_CLR_ROW: wipe_line(cur_row);
    endcase
    r.cursor_col = cur_col[6:0];
    r.cursor_row = cur_row[4:0];
    return r;
  endfunction

  // True where the item would make the block sweep the whole store.
  function automatic bit costly(in_item_t it);
    if (it.operation == OP_CLR_SCR) return 1'b1;
    if (it.operation != OP_PUT || cur_row != ROWS - 1) return 1'b0;
    case (it.character)
      CH_CR, CH_LF: return 1'b1;
      CH_TAB:       return cur_col + TAB_WIDTH - 1 >= COLUMNS;
      CH_BS:        return 1'b0;
      default:      return cur_col >= COLUMNS;
    endcase
  endfunction

  // Reads stay on cells that hold something defined, or fall outside the screen.
  function automatic logic [10:0] pick_read_addr();
    int a;
    if (!any_defined || $urandom_range(0, 9) == 0)
      return 11'($urandom_range(CELLS, ADDR_TOP));
    a = cur_row * COLUMNS + cur_col - 1;
    if ($urandom_range(0, 2) == 0 && a >= 0 && a < CELLS && cell_defined[a])
      return 11'(a);
    repeat (16) begin
      a = $urandom_range(0, CELLS - 1);
      if (cell_defined[a]) return 11'(a);
    end
    return last_written;
  endfunction

  function automatic in_item_t make_item(op_t op, logic [7:0] ch, logic [10:0] addr);
    in_item_t it;
    it.operation    = op;
    it.character    = ch;
    it.cell_address = addr;
    return it;
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(8'h20, 8'h7E));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (!steady && !calm && $urandom_range(0, 5) == 0)
      gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(console_apply(it));
    items_sent++;
  endtask

  task automatic issue(input in_item_t it);
    if (it.operation == OP_READ) begin
      it.cell_address = pick_read_addr();
    end else if (heavy_ops >= HEAVY_MAX && costly(it)) begin
      it.operation = OP_PUT;
      it.character = CH_BS;
    end
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic set_attribute(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    attr_reg = value;
    attr_writes++;
  endtask

  // Cursor at home after reset, then the first row cleared and read back.
  task automatic test_startup_edges();
    send_item(make_item(OP_PUT, CH_BS, 11'd0));
    send_item(make_item(OP_CLR_ROW, 8'hFF, 11'h7FF));
    send_item(make_item(OP_READ, 8'hFF, 11'd0));
    send_item(make_item(OP_READ, 8'h00, 11'd79));
    send_item(make_item(OP_READ, 8'h00, 11'd2000));
    send_item(make_item(OP_READ, 8'h00, 11'h7FF));
  endtask

  task automatic test_screen_clear();
    send_item(make_item(OP_CLR_SCR, 8'h00, 11'h7FF));
    send_item(make_item(OP_READ, 8'h00, 11'd1999));
    send_item(make_item(OP_READ, 8'h55, 11'd1000));
    send_item(make_item(OP_CLR_ROW, 8'hAA, 11'h555));
  endtask

  task automatic test_put_controls();
    send_item(make_item(OP_PUT, 8'h00, 11'd0));
    send_item(make_item(OP_PUT, 8'hFF, 11'h7FF));
    send_item(make_item(OP_PUT, 8'h41, 11'd0));
    send_item(make_item(OP_PUT, CH_TAB, 11'd0));
    send_item(make_item(OP_READ, 8'h00, 11'd1));
    send_item(make_item(OP_READ, 8'h00, 11'd5));
    send_item(make_item(OP_PUT, CH_BS, 11'd0));
    send_item(make_item(OP_PUT, CH_CR, 11'd0));
    send_item(make_item(OP_PUT, CH_LF, 11'd0));
    // Backspace at the start of a row steps back to the row above.
    send_item(make_item(OP_PUT, CH_BS, 11'd0));
    send_item(make_item(OP_PUT, 8'h7E, 11'd0));
  endtask

  task automatic test_random_traffic(input int count);
    int target, kind, ctl;
    logic [7:0] ch;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      calm = ($urandom_range(0, 3) == 0);
      if (kind < 45) begin
        // A line of text, long enough at times to wrap, usually ended by a newline.
        repeat ($urandom_range(1, 100))
          issue(make_item(OP_PUT, text_byte(), 11'($urandom_range(0, ADDR_TOP))));
        if ($urandom_range(0, 9) < 6)
          issue(make_item(OP_PUT, $urandom_range(0, 1) ? CH_CR : CH_LF,
                          11'($urandom_range(0, ADDR_TOP))));
      end else if (kind < 58) begin
        repeat ($urandom_range(1, 6)) begin
          ctl = $urandom_range(0, 2);
          ch  = (ctl == 0) ? CH_TAB : ((ctl == 1) ? CH_BS : text_byte());
          issue(make_item(OP_PUT, ch, 11'($urandom_range(0, ADDR_TOP))));
        end
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 4))
          issue(make_item(OP_READ, 8'($urandom_range(0, 255)), '0));
      end else if (kind < 86) begin
        issue(make_item(OP_CLR_ROW, 8'($urandom_range(0, 255)),
                        11'($urandom_range(0, ADDR_TOP))));
      end else if (kind < 88) begin
        issue(make_item(OP_CLR_SCR, 8'($urandom_range(0, 255)),
                        11'($urandom_range(0, ADDR_TOP))));
      end else if (kind < 90) begin
        // Let the block run dry before carrying on.
        if (!steady) begin
          drain_results();
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
      end else begin
        repeat ($urandom_range(1, 5))
          issue(make_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          11'($urandom_range(0, ADDR_TOP))));
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        if (mismatches < REPORT_MAX)
          $display("%t: result item with nothing expected: char %h colour %h col %0d row %0d",
                   $realtime, out_data.cell_char, out_data.cell_color,
                   out_data.cursor_col, out_data.cursor_row);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.cell_char !== want.cell_char || out_data.cell_color !== want.cell_color ||
            out_data.cursor_col !== want.cursor_col ||
            out_data.cursor_row !== want.cursor_row) begin
          errors++;
          if (mismatches < REPORT_MAX)
            $display({"%t: mismatch: expected char %h colour %h col %0d row %0d, ",
                      "got char %h colour %h col %0d row %0d"},
                     $realtime, want.cell_char, want.cell_color, want.cursor_col,
                     want.cursor_row, out_data.cell_char, out_data.cell_color,
                     out_data.cursor_col, out_data.cursor_row);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%t: no item has moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("tb_text_console_writer_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_startup_edges();
    test_screen_clear();
    test_put_controls();
    drain_results();
    set_attribute(8'h00);
    test_random_traffic(450);
    drain_results();
    set_attribute(8'hFF);
    test_random_traffic(450);
    drain_results();
    set_attribute(8'($urandom_range(1, 254)));
    test_random_traffic(450);
    drain_results();
    // The closing stretch runs with both sides flat out.
    steady = 1'b1;
    set_attribute(8'($urandom_range(0, 255)));
    test_random_traffic(550);
    drain_results();
    repeat (50) @(posedge clk);
    errors += awaited_results.size();
    $display("Run covered %0d items including %0d cell reads, %0d results checked, %0d %s",
             items_sent, reads_done, results_seen, attr_writes, "attribute values.");
    $display("The cursor wrapped %0d times and the screen scrolled %0d times; %0d failures seen.",
             wraps, scrolls, errors);
    if (errors == 0) begin
      $display("tb_text_console_writer_unit: done, clean");
    end else begin
      $display("tb_text_console_writer_unit: done, errors");
    end
    $finish;
  end

endmodule
